// ----- design/wum_pkg.sv -----
`default_nettype none

package wum_pkg;

    // event codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_SET_ACTIVE  = 2'd0,
        OP_SET_COMPUTE = 2'd1,
        OP_CLEAR_FLAGS = 2'd2,
        OP_SAMPLE      = 2'd3
    } t_opcode;

    // register word indexes on the config port
    localparam logic REG_TIME_SHIFT     = 1'b0;
    localparam logic REG_COMPUTE_WEIGHT = 1'b1;

    localparam int unsigned TDATA_IN_W  = 64;
    localparam int unsigned TUSER_IN_W  = 2;
    localparam int unsigned TDATA_OUT_W = 112;
    localparam int unsigned STAMP_W     = 63;
    localparam int unsigned TOTAL_W     = 32;
    localparam int unsigned SHIFT_W     = 5;
    localparam int unsigned WEIGHT_W    = 10;
    localparam int unsigned UTIL_W      = 7;
    localparam int unsigned WSUM_W      = 17;
    localparam int unsigned DIV_CNT_W   = 4;

    localparam logic [TOTAL_W-1:0]   PERCENT         = 32'd100;
    localparam logic [TOTAL_W-1:0]   PERCENT_SQUARED = 32'd10000;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_RESET    = 10'd100;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST        = 4'd15;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_ADD,
        S_DELTA,
        S_MBASE,
        S_DBASE,
        S_MSHARE,
        S_DSHARE,
        S_MW1,
        S_MW2,
        S_MUTIL,
        S_DUTIL,
        S_DONE
    } t_state;

    // two restoring-division steps: returns {remainder, quotient/dividend}
    function automatic logic [63:0] div_step2(input logic [31:0] rem,
                                              input logic [31:0] quo,
                                              input logic [31:0] dvs);
        logic [32:0] trial;
        logic [31:0] r;
        logic [31:0] q;
        r = rem;
        q = quo;
        for (int k = 0; k < 2; k++) begin
            trial = {r, q[31]};
            q = {q[30:0], 1'b0};
            if (trial >= {1'b0, dvs}) begin
                r    = 32'(trial - {1'b0, dvs});
                q[0] = 1'b1;
            end else begin
                r = trial[31:0];
            end
        end
        return {r, q};
    endfunction

endpackage

`default_nettype wire

// ----- design/weighted_utilisation_monitor_top.sv -----
// Non-sample events: ready again after S_DIFF and S_ADD, no result.
// Sample events: S_DELTA through S_DUTIL follow S_ADD, then S_DONE writes the result
// word; one event at a time, and a sample waits in its last state while the
// previous result word is still unaccepted.
// The sample time is set by one shared 2-bit-per-cycle divider run three times
// and one shared 32x32 multiplier used five times.
// Synchronous active-low reset clears totals, snapshots, flags, stamp and
// restores time_shift = 0, compute_weight = 100.
`default_nettype none

module weighted_utilisation_monitor_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // slave stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [62:0] timestamp, [63] flag_value
    input  wire logic [wum_pkg::TDATA_IN_W-1:0]       s_axis_tdata,
    // [1:0] opcode
    input  wire logic [wum_pkg::TUSER_IN_W-1:0]       s_axis_tuser,
    // master stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [6:0] utilisation, [7] compute_boost, [39:8] busy_delta,
    // [71:40] idle_delta, [103:72] compute_delta, [104] compute_exceeds_busy,
    // [111:105] zero
    output logic [wum_pkg::TDATA_OUT_W-1:0]           m_axis_tdata,
    // config port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [2:0]                           paddr,
    input  wire logic [31:0]                          pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);
    import wum_pkg::*;

    t_state r_state, n_state;

    // config registers
    logic [SHIFT_W-1:0]  r_time_shift;
    logic [WEIGHT_W-1:0] r_compute_weight;

    // accumulation state
    logic [STAMP_W-1:0] r_last_stamp;
    logic [TOTAL_W-1:0] r_busy_total, r_idle_total, r_compute_total;
    logic [TOTAL_W-1:0] r_busy_snap, r_idle_snap, r_compute_snap;
    logic               r_active_flag, r_compute_flag;

    // captured event word
    t_opcode            r_op;
    logic [STAMP_W-1:0] r_now;
    logic               r_flag;

    // accumulate pipeline
    logic [TOTAL_W-1:0] r_units;
    logic               r_fwd;

    // sample datapath
    logic [TOTAL_W-1:0] r_busy, r_idle, r_comp;
    logic [TOTAL_W-1:0] r_base;
    logic [UTIL_W-1:0]  r_share;
    logic [TOTAL_W-1:0] r_prod;
    logic [WSUM_W-1:0]  r_wsum;

    // shared divider
    logic [TOTAL_W-1:0]   r_rem, r_quo, r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [63:0]          div_next;
    logic                 div_last;

    // output word
    logic                   r_m_valid;
    logic [TDATA_OUT_W-1:0] r_m_data;

    // shared multiplier
    logic [TOTAL_W-1:0] mul_a, mul_b;
    logic [63:0]        mul_full;
    logic [TOTAL_W-1:0] mul_lo;

    logic [TOTAL_W-1:0] span;
    logic [TOTAL_W-1:0] busy_div;
    logic [TOTAL_W-1:0] elapsed;
    logic [UTIL_W-1:0]  quo_clamped;
    logic               cfg_wr;
    logic               in_take;
    logic               out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign out_free      = !r_m_valid || m_axis_tready;

    // config port: registers decoded on the word address bit
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_TIME_SHIFT:     prdata = {27'd0, r_time_shift};
            REG_COMPUTE_WEIGHT: prdata = {22'd0, r_compute_weight};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_shift     <= '0;
            r_compute_weight <= WEIGHT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_TIME_SHIFT) begin
                r_time_shift <= pwdata[SHIFT_W-1:0];
            end else begin
                r_compute_weight <= pwdata[WEIGHT_W-1:0];
            end
        end
    end

    // shared multiplier operand select, low 32 bits kept
    always_comb begin
        unique case (r_state)
            S_MBASE: begin
                mul_a = r_busy;
                mul_b = PERCENT;
            end
            S_MSHARE: begin
                mul_a = r_comp;
                mul_b = PERCENT;
            end
            S_MW1: begin
                mul_a = {22'd0, r_compute_weight};
                mul_b = {25'd0, r_share};
            end
            S_MW2: begin
                mul_a = PERCENT - {25'd0, r_share};
                mul_b = PERCENT;
            end
            S_MUTIL: begin
                mul_a = r_base;
                mul_b = {15'd0, r_wsum + {3'd0, r_prod[13:0]}};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign mul_lo   = mul_full[TOTAL_W-1:0];

    // divisors, with zero replaced by one
    assign span     = (r_busy + r_idle == '0) ? 32'd1 : r_busy + r_idle;
    assign busy_div = (r_busy == '0) ? 32'd1 : r_busy;

    assign div_next    = div_step2(r_rem, r_quo, r_dvs);
    assign div_last    = (r_cnt == DIV_LAST);
    assign quo_clamped = (div_next[31:0] > PERCENT) ? UTIL_W'(PERCENT)
                                                   : div_next[UTIL_W-1:0];

    assign elapsed = r_now[TOTAL_W-1:0] - r_last_stamp[TOTAL_W-1:0];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_take) n_state = S_DIFF;
            S_DIFF:   n_state = S_ADD;
            S_ADD:    n_state = (r_op == OP_SAMPLE) ? S_DELTA : S_IDLE;
            S_DELTA:  n_state = S_MBASE;
            S_MBASE:  n_state = S_DBASE;
            S_DBASE:  if (div_last) n_state = S_MSHARE;
            S_MSHARE: n_state = S_DSHARE;
            S_DSHARE: if (div_last) n_state = S_MW1;
            S_MW1:    n_state = S_MW2;
            S_MW2:    n_state = S_MUTIL;
            S_MUTIL:  n_state = S_DUTIL;
            S_DUTIL:  if (div_last) n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // event capture
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op   <= t_opcode'(s_axis_tuser);
            r_now  <= s_axis_tdata[STAMP_W-1:0];
            r_flag <= s_axis_tdata[STAMP_W];
        end
    end

    // elapsed time: backwards time blocks the update
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIFF) begin
            r_fwd   <= (r_now >= r_last_stamp);
            r_units <= elapsed >> r_time_shift;
        end
    end

    // totals, flags, stamp and snapshots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_stamp    <= '0;
            r_busy_total    <= '0;
            r_idle_total    <= '0;
            r_compute_total <= '0;
            r_busy_snap     <= '0;
            r_idle_snap     <= '0;
            r_compute_snap  <= '0;
            r_active_flag   <= 1'b0;
            r_compute_flag  <= 1'b0;
        end else if (r_state == S_ADD) begin
            if (r_fwd) begin
                r_last_stamp <= r_now;
                if (r_active_flag) begin
                    r_busy_total <= r_busy_total + r_units;
                end else begin
                    r_idle_total <= r_idle_total + r_units;
                end
                if (r_compute_flag) begin
                    r_compute_total <= r_compute_total + r_units;
                end
            end
            unique case (r_op)
                OP_SET_ACTIVE:  r_active_flag <= r_flag;
                OP_SET_COMPUTE: r_compute_flag <= r_flag;
                OP_CLEAR_FLAGS: begin
                    r_active_flag  <= 1'b0;
                    r_compute_flag <= 1'b0;
                end
                OP_SAMPLE: ;
                default: ;
            endcase
        end else if (r_state == S_DELTA) begin
            r_busy_snap    <= r_busy_total;
            r_idle_snap    <= r_idle_total;
            r_compute_snap <= r_compute_total;
        end
    end

    // sample sequence on the shared multiplier and divider
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_DELTA: begin
                r_busy <= r_busy_total - r_busy_snap;
                r_idle <= r_idle_total - r_idle_snap;
                r_comp <= r_compute_total - r_compute_snap;
            end
            S_MBASE: begin
                r_rem <= '0;
                r_quo <= mul_lo;
                r_dvs <= span;
                r_cnt <= '0;
            end
            S_MSHARE: begin
                r_rem <= '0;
                r_quo <= mul_lo;
                r_dvs <= busy_div;
                r_cnt <= '0;
            end
            S_MUTIL: begin
                r_rem <= '0;
                r_quo <= mul_lo;
                r_dvs <= PERCENT_SQUARED;
                r_cnt <= '0;
            end
            S_DBASE, S_DSHARE, S_DUTIL: begin
                r_rem <= div_next[63:32];
                r_quo <= div_next[31:0];
                r_cnt <= r_cnt + 1'b1;
                if (div_last && r_state == S_DBASE) begin
                    r_base <= div_next[31:0];
                end
                if (div_last && r_state == S_DSHARE) begin
                    r_share <= quo_clamped;
                end
            end
            S_MW1: r_prod <= mul_lo;
            S_MW2: begin
                r_wsum <= r_prod[WSUM_W-1:0];
                r_prod <= mul_lo;
            end
            default: ;
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // r_quo holds the final util quotient until the next sample
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_m_data <= {7'd0,
                         (r_comp > r_busy),
                         r_comp,
                         r_idle,
                         r_busy,
                         (r_share != '0),
                         (r_quo > PERCENT) ? UTIL_W'(PERCENT) : r_quo[UTIL_W-1:0]};
        end
    end

endmodule

`default_nettype wire

// ----- design/wum_checker.sv -----
`default_nettype none

module wum_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [wum_pkg::TDATA_OUT_W-1:0]    m_axis_tdata
);
    import wum_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // one event at a time: busy right after an accept
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an event is in progress");

    // utilisation is clamped to a percent
    a_util_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[6:0] <= 7'd100)
        else $error("utilisation above 100");

    // error flag agrees with the reported deltas
    a_exceeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[104] == (m_axis_tdata[103:72] > m_axis_tdata[39:8]))
        else $error("compute_exceeds_busy mismatch");

    // a boost needs compute time in the window
    a_boost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[103:72] != 32'd0)
        else $error("compute_boost without compute time");

endmodule

bind weighted_utilisation_monitor_top wum_checker u_wum_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- verif/weighted_utilisation_monitor_top_test.sv -----
`timescale 1ns / 1ps

module weighted_utilisation_monitor_top_test;
    import wum_pkg::*;

    localparam logic [31:0] PCT          = 32'd100;
    localparam logic [31:0] PCT_SQ       = 32'd10000;
    localparam logic [63:0] STAMP_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int unsigned N_PHASES     = 6;
    localparam int unsigned PHASE_WORDS  = 150;
    localparam int unsigned SETTLE_CYCLES = 80;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned MAX_REPORTS  = 10;

    // one sample result, fields as carried on the output stream
    typedef struct packed {
        logic [6:0]  util;
        logic        boost;
        logic [31:0] busy;
        logic [31:0] idle;
        logic [31:0] comp;
        logic        exceeds;
    } t_sample;

    // tracks busy/idle/compute totals and predicts each sample word
    class utilisation_tracker;
        logic [63:0] last_stamp;
        logic [31:0] busy_total, idle_total, compute_total;
        logic [31:0] busy_mark, idle_mark, compute_mark;
        bit          active, computing;
        logic [4:0]  shift;
        logic [9:0]  weight;
        t_sample     pending_samples[$];
        int unsigned fail_count;

        function new();
            last_stamp    = '0;
            busy_total    = '0;
            idle_total    = '0;
            compute_total = '0;
            busy_mark     = '0;
            idle_mark     = '0;
            compute_mark  = '0;
            active        = 1'b0;
            computing     = 1'b0;
            shift         = '0;
            weight        = 10'd100;
            fail_count    = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == REG_TIME_SHIFT) begin
                shift = value[4:0];
            end else begin
                weight = value[9:0];
            end
        endfunction

        function int unsigned pending();
            return pending_samples.size();
        endfunction

        function void flag_failure(string msg);
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("%s", msg);
            end
        endfunction

        function void note_event(t_opcode op, logic [62:0] stamp, bit flag);
            logic [63:0] now;
            logic [31:0] units, span, base, share, mix, prod, scaled;
            t_sample     s;
            now = {1'b0, stamp};
            // accumulate elapsed time unless time went backwards
            if (now >= last_stamp) begin
                units = (now[31:0] - last_stamp[31:0]) >> shift;
                if (active) begin
                    busy_total = busy_total + units;
                end else begin
                    idle_total = idle_total + units;
                end
                if (computing) begin
                    compute_total = compute_total + units;
                end
                last_stamp = now;
            end
            case (op)
                OP_SET_ACTIVE: begin
                    active = flag;
                end
                OP_SET_COMPUTE: begin
                    computing = flag;
                end
                OP_CLEAR_FLAGS: begin
                    active    = 1'b0;
                    computing = 1'b0;
                end
                default: begin
                    s.busy = busy_total - busy_mark;
                    s.idle = idle_total - idle_mark;
                    s.comp = compute_total - compute_mark;
                    // all products wrap at 32 bits; zero divisors become one
                    span = s.busy + s.idle;
                    if (span == 0) begin
                        span = 32'd1;
                    end
                    prod  = PCT * s.busy;
                    base  = prod / span;
                    prod  = PCT * s.comp;
                    share = prod / ((s.busy == 0) ? 32'd1 : s.busy);
                    if (share > PCT) begin
                        share = PCT;
                    end
                    mix    = 32'(weight) * share + PCT * (PCT - share);
                    prod   = base * mix;
                    scaled = prod / PCT_SQ;
                    if (scaled > PCT) begin
                        scaled = PCT;
                    end
                    s.util    = scaled[6:0];
                    s.boost   = (share != 0);
                    s.exceeds = (s.comp > s.busy);
                    pending_samples.push_back(s);
                    busy_mark    = busy_total;
                    idle_mark    = idle_total;
                    compute_mark = compute_total;
                end
            endcase
        endfunction

        function void check_sample(logic [TDATA_OUT_W-1:0] word);
            t_sample want, got;
            got.util    = word[6:0];
            got.boost   = word[7];
            got.busy    = word[39:8];
            got.idle    = word[71:40];
            got.comp    = word[103:72];
            got.exceeds = word[104];
            if (pending_samples.size() == 0) begin
                flag_failure($sformatf("unexpected sample word %h", word));
                return;
            end
            want = pending_samples.pop_front();
            if (got.util !== want.util || got.boost !== want.boost ||
                got.busy !== want.busy || got.idle !== want.idle ||
                got.comp !== want.comp || got.exceeds !== want.exceeds) begin
                flag_failure($sformatf(
                    {"sample mismatch: exp util=%0d boost=%0d busy=%0d idle=%0d comp=%0d",
                     " err=%0d | got util=%0d boost=%0d busy=%0d idle=%0d comp=%0d err=%0d"},
                    want.util, want.boost, want.busy, want.idle, want.comp, want.exceeds,
                    got.util, got.boost, got.busy, got.idle, got.comp, got.exceeds));
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata;   // [62:0] timestamp, [63] flag_value
    logic [TUSER_IN_W-1:0]  s_axis_tuser;   // [1:0] opcode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [6:0] utilisation, [7] compute_boost, [39:8] busy_delta, [71:40] idle_delta,
    // [103:72] compute_delta, [104] compute_exceeds_busy
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    utilisation_tracker tracker = new();

    weighted_utilisation_monitor_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // hard stop
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // sender idle length: mostly short, a few long
    function automatic int unsigned pick_gap(bit steady);
        int unsigned r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // next event time: mostly forward, some huge jumps, some backwards
    function automatic logic [62:0] next_stamp(inout logic [63:0] cursor);
        int unsigned r;
        logic [63:0] step;
        r = $urandom_range(99);
        if (r >= 90) begin
            step = 64'($urandom_range(100000, 1));
            return (cursor > step) ? 63'(cursor - step) : cursor[62:0];
        end
        if (r < 60) begin
            step = 64'($urandom_range(5000));
        end else if (r < 75) begin
            step = 64'($urandom_range(1 << 20));
        end else if (r < 83) begin
            step = '0;
        end else begin
            step = (64'($urandom_range(3)) << 32) | 64'($urandom);
        end
        cursor = (STAMP_MAX - cursor < step) ? STAMP_MAX : cursor + step;
        return cursor[62:0];
    endfunction

    // all tasks below start and end on a falling edge
    task automatic send_event(t_opcode op, logic [62:0] stamp, bit flag, int unsigned gap);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {flag, stamp};
        s_axis_tuser  = op;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_event(op, stamp, flag);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        tracker.set_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic wait_drained(int unsigned extra);
        s_axis_tvalid = 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    // result side: check on the rising edge, random stalls set on the falling edge
    initial begin : result_sink
        int unsigned hold, r;
        bit rdy;
        hold = 0;
        rdy  = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                tracker.check_sample(m_axis_tdata);
            end
            @(negedge i_clk);
            if (hold == 0) begin
                r = $urandom_range(99);
                if (r < 50) begin
                    rdy  = 1'b1;
                    hold = $urandom_range(8, 1);
                end else if (r < 60) begin
                    rdy  = 1'b1;
                    hold = $urandom_range(200, 50);
                end else if (r < 90) begin
                    rdy  = 1'b0;
                    hold = $urandom_range(3, 1);
                end else begin
                    rdy  = 1'b0;
                    hold = $urandom_range(80, 10);
                end
            end
            m_axis_tready = rdy;
            hold--;
        end
    end

    initial begin : stimulus
        logic [63:0] cursor, base, t0;
        logic [4:0]  shift_set [N_PHASES];
        logic [9:0]  weight_set [N_PHASES];
        t_opcode     op;
        int unsigned r;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_SET_ACTIVE;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty window, flags, backwards time, error case, huge elapsed
        send_event(OP_SAMPLE,      63'd0,   1'b0, pick_gap(1'b0));
        send_event(OP_SET_ACTIVE,  63'd100, 1'b1, pick_gap(1'b0));
        send_event(OP_SET_COMPUTE, 63'd160, 1'b1, pick_gap(1'b0));
        send_event(OP_SAMPLE,      63'd400, 1'b1, pick_gap(1'b0));
        send_event(OP_SET_ACTIVE,  63'd50,  1'b0, pick_gap(1'b0));
        send_event(OP_SAMPLE,      63'd700, 1'b0, pick_gap(1'b0));
        send_event(OP_CLEAR_FLAGS, 63'd900, 1'b1, pick_gap(1'b0));
        send_event(OP_SET_COMPUTE, 63'd1000, 1'b1, pick_gap(1'b0));
        send_event(OP_SAMPLE,      63'd1300, 1'b0, pick_gap(1'b0));
        send_event(OP_SET_COMPUTE, 63'd1300, 1'b0, pick_gap(1'b0));
        send_event(OP_SET_ACTIVE,  63'd1500, 1'b1, pick_gap(1'b0));
        t0 = 64'd1500 + (64'd1 << 33) + 64'd4321;
        send_event(OP_SAMPLE,      t0[62:0], 1'b0, pick_gap(1'b0));
        send_event(OP_SAMPLE,      t0[62:0], 1'b1, pick_gap(1'b0));
        send_event(OP_SET_ACTIVE,  63'(t0 + 64'd10), 1'b0, pick_gap(1'b0));
        send_event(OP_SAMPLE,      63'(t0 + 64'd500000), 1'b0, pick_gap(1'b0));
        cursor = t0 + 64'd500000;

        // register settings per phase, extremes included; phase 0 keeps reset values
        shift_set[1] = 5'd0;  weight_set[1] = 10'd1000;
        shift_set[2] = 5'd31; weight_set[2] = 10'd0;
        shift_set[3] = 5'd4;  weight_set[3] = 10'($urandom_range(1000));
        shift_set[4] = 5'($urandom_range(31));
        weight_set[4] = 10'($urandom_range(1000));
        shift_set[5] = 5'd1;  weight_set[5] = 10'd1000;

        for (int p = 0; p < N_PHASES; p++) begin
            if (p != 0) begin
                wait_drained(SETTLE_CYCLES);
                write_reg(REG_TIME_SHIFT, 32'(shift_set[p]));
                write_reg(REG_COMPUTE_WEIGHT, 32'(weight_set[p]));
            end
            // each phase starts at a higher time band so all stamp bits toggle
            base = (p == N_PHASES - 1) ? (STAMP_MAX - (64'd1 << 46)) : (64'(p) << 58);
            base = base + ({32'($urandom), 32'($urandom)} & ((64'd1 << 45) - 1));
            if (base > cursor) begin
                cursor = base;
            end
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (p == 2 && i == PHASE_WORDS / 2) begin
                    wait_drained(0);
                end
                r = $urandom_range(99);
                if (r < 35) begin
                    op = OP_SET_ACTIVE;
                end else if (r < 55) begin
                    op = OP_SET_COMPUTE;
                end else if (r < 63) begin
                    op = OP_CLEAR_FLAGS;
                end else begin
                    op = OP_SAMPLE;
                end
                send_event(op, next_stamp(cursor), 1'($urandom_range(1)), pick_gap(p == 1));
            end
        end

        // latest representable time
        send_event(OP_SET_ACTIVE, 63'(STAMP_MAX - 64'd1000), 1'b1, pick_gap(1'b0));
        send_event(OP_SAMPLE,     STAMP_MAX[62:0],          1'b1, pick_gap(1'b0));

        wait_drained(DRAIN_CYCLES);
        if (tracker.fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/wum_pkg.sv
design/weighted_utilisation_monitor_top.sv
design/wum_checker.sv
verif/weighted_utilisation_monitor_top_test.sv
